// File: rtl/core/mhwe_pkg.sv
// ----------------------------------------------------------------------------
// mhwe_pkg: shared types and constants of the MIME header word encoder
// Item types, the command passed from the front part to the back part,
// character codes and lookup functions for the Q-encoding byte sequences.
// ----------------------------------------------------------------------------
package mhwe_pkg;

    // Input item: header byte and the byte after it
    typedef struct packed {
        logic [7:0] in_char;
        logic [7:0] next_char;
    } in_item_t;

    // Output item: one encoded byte with run markers
    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       header_done;
    } out_item_t;

    // Body action for one input byte
    typedef enum logic [1:0] {
        BODY_BYTE,
        BODY_HEX,
        BODY_CLOSE
    } body_kind_t;

    // Back part emit phases, in output order
    typedef enum logic [1:0] {
        PH_OPEN,
        PH_BODY,
        PH_FOLD,
        PH_FINAL
    } phase_t;

    // Command from front to back: what to emit for one input item
    typedef struct packed {
        logic [7:0] ch;        // body byte (or the byte to hex encode)
        body_kind_t kind;
        logic       has_open;  // leading encoded-word opener
        logic       has_fold;  // close, fold and reopen after the body
        logic       has_final; // closing "?=" at end of header
        logic       last;      // last item of the header
    } cmd_t;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Column handling
    localparam logic [6:0] COL_MAX    = 7'd127;
    localparam logic [6:0] FOLD_LIMIT = 7'd70;
    localparam logic [4:0] OPEN_LEN   = 5'd15;

    // Phase lengths minus one
    localparam logic [4:0] OPEN_END   = 5'd14;
    localparam logic [4:0] FOLD_END   = 5'd18;
    localparam logic [4:0] FINAL_END  = 5'd1;
    localparam logic [4:0] TRIPLE_END = 5'd2;
    localparam logic [4:0] FOLD_HEAD  = 5'd4;   // bytes before the reopen in a fold

    // Encoded-word opener "=?ISO-8859-1?Q?"
    function automatic logic [7:0] open_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "=";
            4'd1:    ch = "?";
            4'd2:    ch = "I";
            4'd3:    ch = "S";
            4'd4:    ch = "O";
            4'd5:    ch = "-";
            4'd6:    ch = "8";
            4'd7:    ch = "8";
            4'd8:    ch = "5";
            4'd9:    ch = "9";
            4'd10:   ch = "-";
            4'd11:   ch = "1";
            4'd12:   ch = "?";
            4'd13:   ch = "Q";
            default: ch = "?";
        endcase
        return ch;
    endfunction

    // Uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

    // Saturating column add
    function automatic logic [6:0] col_add(input logic [6:0] col, input logic [4:0] n);
        logic [7:0] sum;
        sum = {1'b0, col} + {3'd0, n};
        return (sum > {1'b0, COL_MAX}) ? COL_MAX : sum[6:0];
    endfunction

endpackage

// File: rtl/core/mhwe_front.sv
// ----------------------------------------------------------------------------
// mhwe_front: classify header bytes
// Keeps the encoded-word flag and column count, and turns each accepted item
// into one command for the back part.
// ----------------------------------------------------------------------------
module mhwe_front
    import mhwe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t header_item,
    output logic     cmd_push,
    input  logic     cmd_full,
    output cmd_t     cmd
);

    logic       in_word_reg, in_word_next;
    logic [6:0] col_reg, col_next;

    logic [7:0] c, nx;
    logic       last, opens, word1, is_hex, is_closer, next_opener;
    logic [6:0] col1, col2;
    logic       word2;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    // Classification and next state
    always_comb
    begin
        c           = header_item.in_char;
        nx          = header_item.next_char;
        last        = (nx == CH_NUL);
        opens       = !in_word_reg && c[7];
        word1       = in_word_reg || opens;
        col1        = opens ? col_add(col_reg, OPEN_LEN) : col_reg;
        is_hex      = c[7] || (c == CH_EQ) || (c == CH_QMARK) || (c == CH_USCORE);
        is_closer   = (c == CH_GT) || (c == CH_RPAREN) || (c == CH_DQUOTE);
        next_opener = (nx == CH_LT) || (nx == CH_LPAREN) || (nx == CH_DQUOTE);

        cmd.ch        = c;
        cmd.kind      = BODY_BYTE;
        cmd.has_open  = opens;
        cmd.has_fold  = 1'b0;
        cmd.has_final = 1'b0;
        cmd.last      = last;
        word2         = word1;
        col2          = col_add(col1, 5'd1);

        if (word1)
        begin
            if (c == CH_SPACE)
            begin
                if (next_opener)
                begin
                    cmd.kind = BODY_CLOSE;
                    word2    = 1'b0;
                    col2     = 7'd0;
                end
                else
                begin
                    cmd.ch = CH_USCORE;
                end
            end
            else if (is_hex)
            begin
                cmd.kind = BODY_HEX;
                col2     = col_add(col1, 5'd3);
            end
            else if (is_closer)
            begin
                cmd.kind = BODY_CLOSE;
                word2    = 1'b0;
                col2     = 7'd0;
            end
            // fold an overlong word
            if ((col2 > FOLD_LIMIT) && !last)
            begin
                cmd.has_fold = 1'b1;
                col2         = {2'd0, OPEN_LEN};
            end
        end
        else if (c == CH_SPACE)
        begin
            col2 = 7'd0;
        end

        // end of header clears the state
        cmd.has_final = last && word2;
        in_word_next  = last ? 1'b0 : word2;
        col_next      = last ? 7'd0 : col2;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            col_reg     <= 7'd0;
        end
        else if (cmd_push)
        begin
            in_word_reg <= in_word_next;
            col_reg     <= col_next;
        end
    end

endmodule

// File: rtl/core/mhwe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mhwe_cmd_fifo: command queue between front and back
// Small register FIFO with first-word-fall-through read.
// ----------------------------------------------------------------------------
module mhwe_cmd_fifo
    import mhwe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic wr_full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic rd_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign wr_full  = (count_reg == FULL_CNT);
    assign rd_empty = (count_reg == '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/mhwe_back.sv
// ----------------------------------------------------------------------------
// mhwe_back: expand commands into output bytes
// Walks the opener, body, fold and closing phases of each command, one byte
// per cycle while pop keeps the output stage free, into a registered output stage.
// ----------------------------------------------------------------------------
module mhwe_back
    import mhwe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd_head,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    output out_item_t encoded_item,
    output logic      empty,
    input  logic      pop
);

    phase_t     phase_reg, phase_next;
    logic [4:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    cmd_t       cmd_reg, cmd_next;
    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       advance, phase_end, more, load;
    phase_t     phase_after;
    logic [7:0] cur_byte;
    logic [4:0] fold_off;

    assign empty        = !out_valid_reg;
    assign encoded_item = out_reg;

    // Current byte and phase bookkeeping
    always_comb
    begin
        fold_off = idx_reg - FOLD_HEAD;
        cur_byte = CH_NUL;
        unique case (phase_reg)
            PH_OPEN:
            begin
                cur_byte    = open_char(idx_reg[3:0]);
                phase_end   = (idx_reg == OPEN_END);
                more        = 1'b1;
                phase_after = PH_BODY;
            end
            PH_BODY:
            begin
                unique case (cmd_reg.kind)
                    BODY_HEX:
                    begin
                        priority if (idx_reg == 5'd0) cur_byte = CH_EQ;
                        else if (idx_reg == 5'd1) cur_byte = hex_char(cmd_reg.ch[7:4]);
                        else cur_byte = hex_char(cmd_reg.ch[3:0]);
                    end
                    BODY_CLOSE:
                    begin
                        priority if (idx_reg == 5'd0) cur_byte = CH_QMARK;
                        else if (idx_reg == 5'd1) cur_byte = CH_EQ;
                        else cur_byte = cmd_reg.ch;
                    end
                    default: cur_byte = cmd_reg.ch;
                endcase
                phase_end   = (cmd_reg.kind == BODY_BYTE) ? (idx_reg == 5'd0)
                                                          : (idx_reg == TRIPLE_END);
                more        = cmd_reg.has_fold || cmd_reg.has_final;
                phase_after = cmd_reg.has_fold ? PH_FOLD : PH_FINAL;
            end
            PH_FOLD:
            begin
                priority if (idx_reg == 5'd0) cur_byte = CH_QMARK;
                else if (idx_reg == 5'd1) cur_byte = CH_EQ;
                else if (idx_reg == 5'd2) cur_byte = CH_NL;
                else if (idx_reg == 5'd3) cur_byte = CH_SPACE;
                else cur_byte = open_char(fold_off[3:0]);
                phase_end   = (idx_reg == FOLD_END);
                more        = cmd_reg.has_final;
                phase_after = PH_FINAL;
            end
            PH_FINAL:
            begin
                cur_byte    = (idx_reg == 5'd0) ? CH_QMARK : CH_EQ;
                phase_end   = (idx_reg == FINAL_END);
                more        = 1'b0;
                phase_after = PH_FINAL;
            end
            default:
            begin
                phase_end   = 1'b1;
                more        = 1'b0;
                phase_after = PH_FINAL;
            end
        endcase
    end

    // Next state and output stage
    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        load           = 1'b0;
        advance        = busy_reg && (!out_valid_reg || pop);

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            load = !cmd_empty;
        end
        else if (advance)
        begin
            out_next.out_char    = cur_byte;
            out_next.run_last    = phase_end && !more;
            out_next.header_done = phase_end && !more && cmd_reg.last;
            out_valid_next       = 1'b1;
            if (phase_end)
            begin
                if (!more)
                begin
                    load      = !cmd_empty;
                    busy_next = 1'b0;
                end
                else
                begin
                    phase_next = phase_after;
                    idx_next   = 5'd0;
                end
            end
            else
            begin
                idx_next = idx_reg + 5'd1;
            end
        end

        // take the next command
        if (load)
        begin
            cmd_next   = cmd_head;
            busy_next  = 1'b1;
            idx_next   = 5'd0;
            phase_next = cmd_head.has_open ? PH_OPEN : PH_BODY;
        end
        cmd_pop = load;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BODY;
            idx_reg       <= 5'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

endmodule

// File: rtl/core/mime_header_word_encoder.sv
// ----------------------------------------------------------------------------
// mime_header_word_encoder: Q-encoded header word encoder, ISO-8859-1
// Top level: front classifier, command queue and byte-serial back part.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive header_item (header byte plus the byte after it, 0 for
//   the last one) and raise push; the item is taken on an edge with full low.
//   Output queue: while empty is low, encoded_item holds the oldest byte;
//   raise pop to take it. run_last marks the last byte of an input item and
//   header_done the final byte of the header.
// Path: an accepted item goes through the command queue and the back part's
//   command register; its first byte then appears in the output register.
// Throughput: one output byte per cycle while pop keeps up. An item producing
//   n bytes (1 to 37) is emitted byte by byte; the back part serializes bytes
//   and sets the rate. An idle gap appears only when it runs dry between items.
// Stall: if pop stays low, the output register holds, the back part stops,
//   the command queue fills and full rises; nothing is dropped.
// Reset: rst_n clears the encoded-word flag, the column count, the queue and
//   the output stage; empty is high and full low after reset.
// ----------------------------------------------------------------------------
module mime_header_word_encoder
    import mhwe_pkg::*;
#(
    parameter int CMD_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  header_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t encoded_item
);

    cmd_t front_cmd, head_cmd;
    logic cmd_push, cmd_full, cmd_pop, cmd_empty;

    // Front part
    mhwe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .header_item (header_item),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .cmd         (front_cmd)
    );

    // Command queue
    mhwe_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (front_cmd),
        .wr_full  (cmd_full),
        .rd_en    (cmd_pop),
        .rd_data  (head_cmd),
        .rd_empty (cmd_empty)
    );

    // Back part
    mhwe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_head     (head_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .encoded_item (encoded_item),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
